// ===== rtl/hwsi_pkg.sv =====
// ----------------------------------------------------------------------------
// Hashed word set package
// Shared constants, status and kind codes, and types for the hashed word set.
// ----------------------------------------------------------------------------
package hwsi_pkg;

    localparam int TABLE_SLOTS = 15877;
    localparam int MAX_WORDS   = 4096;
    localparam int MAX_CHARS   = 16;

    localparam int CHAR_W      = 8;
    localparam int HALF_W      = 64;
    localparam int WORD_W      = 2 * HALF_W;
    localparam int WORD_BYTES  = WORD_W / CHAR_W;
    localparam int LEN_W       = $clog2(MAX_CHARS + 1);
    localparam int CHAR_IDX_W  = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
    localparam int SLOT_W      = 14;
    localparam int SLOT_ADDR_W = $clog2(TABLE_SLOTS);
    localparam int PROBE_W     = $clog2(TABLE_SLOTS);
    localparam int POS_W       = 12;
    localparam int ORDER_ADDR_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int COUNT_W     = 13;
    localparam int STATUS_W    = 3;
    localparam int KIND_W      = 2;

    localparam int HASH_W      = 32;
    localparam logic [HASH_W-1:0] HASH_SEED = 32'd5381;
    localparam int HASH_SHIFT  = 5;
    localparam int MOD_DIGIT   = 4;
    localparam int MOD_STEPS   = HASH_W / MOD_DIGIT;
    localparam int MOD_STEP_W  = $clog2(MOD_STEPS);
    localparam logic [SLOT_ADDR_W:0] SLOTS_EXT = (SLOT_ADDR_W + 1)'(TABLE_SLOTS);

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_RESET  = 2'd1,
        KIND_READ   = 2'd2
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_ADDED     = 3'd0,
        STATUS_PRESENT   = 3'd1,
        STATUS_FULL      = 3'd2,
        STATUS_RESET     = 3'd3,
        STATUS_READ_OK   = 3'd4,
        STATUS_OUT_RANGE = 3'd5
    } status_t;

    typedef struct packed {
        logic busy;
        logic done;
    } hash_stat_t;

    typedef struct packed {
        logic              used;
        logic [LEN_W-1:0]  len;
        logic [HALF_W-1:0] hi;
        logic [HALF_W-1:0] lo;
    } slot_entry_t;

endpackage

// ===== rtl/hwsi_hash.sv =====
// ----------------------------------------------------------------------------
// Hashed word set home slot unit
// Runs djb2 one character per cycle, then reduces the 32-bit hash modulo the
// table size with a restoring divider that retires four bits per cycle.
// ----------------------------------------------------------------------------
module hwsi_hash
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [hwsi_pkg::WORD_W-1:0]          word,
    input  logic [hwsi_pkg::LEN_W-1:0]           len,
    output hwsi_pkg::hash_stat_t                 stat,
    output logic [hwsi_pkg::SLOT_ADDR_W-1:0]     home_slot
);

    typedef enum logic [2:0] {
        H_IDLE = 3'b001,
        H_CHAR = 3'b010,
        H_MOD  = 3'b100
    } hstate_t;

    hstate_t                               state_reg, state_next;
    logic [hwsi_pkg::HASH_W-1:0]           h_reg, h_next;
    logic [hwsi_pkg::LEN_W-1:0]            char_idx_reg, char_idx_next;
    logic [hwsi_pkg::HASH_W-1:0]           div_reg, div_next;
    logic [hwsi_pkg::SLOT_ADDR_W-1:0]      rem_reg, rem_next;
    logic [hwsi_pkg::MOD_STEP_W-1:0]       step_reg, step_next;
    logic                                  done_reg, done_next;
    logic [hwsi_pkg::CHAR_W-1:0]           cur_char;
    logic [hwsi_pkg::HASH_W-1:0]           h_step;
    logic [hwsi_pkg::SLOT_ADDR_W-1:0]      rem_step;

    assign cur_char = word[char_idx_reg[hwsi_pkg::CHAR_IDX_W-1:0] * hwsi_pkg::CHAR_W +:
                           hwsi_pkg::CHAR_W];
    assign h_step   = (h_reg << hwsi_pkg::HASH_SHIFT) + h_reg +
                      hwsi_pkg::HASH_W'(cur_char);

    always_comb
    begin
        logic [hwsi_pkg::SLOT_ADDR_W:0]   trial;
        logic [hwsi_pkg::SLOT_ADDR_W-1:0] r;
        r = rem_reg;
        for (int k = 0; k < hwsi_pkg::MOD_DIGIT; k++)
        begin
            trial = {r, div_reg[hwsi_pkg::HASH_W-1-k]};
            if (trial >= hwsi_pkg::SLOTS_EXT)
            begin
                trial = trial - hwsi_pkg::SLOTS_EXT;
            end
            r = trial[hwsi_pkg::SLOT_ADDR_W-1:0];
        end
        rem_step = r;
    end

    always_comb
    begin
        state_next    = state_reg;
        h_next        = h_reg;
        char_idx_next = char_idx_reg;
        div_next      = div_reg;
        rem_next      = rem_reg;
        step_next     = step_reg;
        done_next     = 1'b0;
        case (state_reg)
            H_IDLE:
            begin
                if (start)
                begin
                    h_next        = hwsi_pkg::HASH_SEED;
                    char_idx_next = '0;
                    div_next      = hwsi_pkg::HASH_SEED;
                    rem_next      = '0;
                    step_next     = '0;
                    state_next    = (len == '0) ? H_MOD : H_CHAR;
                end
            end
            H_CHAR:
            begin
                h_next        = h_step;
                char_idx_next = char_idx_reg + 1'b1;
                if (char_idx_reg + 1'b1 == len)
                begin
                    div_next   = h_step;
                    state_next = H_MOD;
                end
            end
            H_MOD:
            begin
                rem_next  = rem_step;
                div_next  = div_reg << hwsi_pkg::MOD_DIGIT;
                step_next = step_reg + 1'b1;
                if (step_reg == hwsi_pkg::MOD_STEP_W'(hwsi_pkg::MOD_STEPS - 1))
                begin
                    done_next  = 1'b1;
                    state_next = H_IDLE;
                end
            end
            default:
            begin
                state_next = H_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= H_IDLE;
            done_reg  <= 1'b0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg        <= h_next;
        char_idx_reg <= char_idx_next;
        div_reg      <= div_next;
        rem_reg      <= rem_next;
    end

    assign stat.busy = (state_reg != H_IDLE);
    assign stat.done = done_reg;
    assign home_slot = rem_reg;

endmodule

// ===== rtl/hashed_word_set_insert_top.sv =====
// ----------------------------------------------------------------------------
// Hashed word set top level
// Deduplicating set of words of up to 16 characters in an open-addressed
// table with linear probing, an insertion-order list and readback.
//
// The input channel takes one transaction per operation: kind selects insert,
// reset set or read; the word fields serve insert and position serves read.
// The output channel returns exactly one result transaction per insert, reset
// or read; an unused kind is taken and returns nothing.
// After reset the block sweeps the slot table once, one slot per cycle, and
// holds in_stall high until that sweep ends. The block works on one
// transaction at a time; in_stall is low only while the sequencer is idle.
// An insert result is valid once the block has started the hash, hashed each
// character, run the modulo, taken the home slot, read and checked each probe
// through the single slot memory read port and loaded the output register. A
// read result follows an order list read and a slot read, a reset set result
// a read and a clear for each stored word. The next transaction can be taken
// in the cycle after the result is loaded. A stalled result holds, and the
// next transaction may be taken and worked on meanwhile, waiting at its end
// for the output register.
// ----------------------------------------------------------------------------
module hashed_word_set_insert_top
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [hwsi_pkg::KIND_W-1:0]        kind,
    input  logic [hwsi_pkg::HALF_W-1:0]        word_lo,
    input  logic [hwsi_pkg::HALF_W-1:0]        word_hi,
    input  logic [hwsi_pkg::LEN_W-1:0]         word_len,
    input  logic [hwsi_pkg::POS_W-1:0]         position,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [hwsi_pkg::STATUS_W-1:0]      status,
    output logic [hwsi_pkg::HALF_W-1:0]        out_word_lo,
    output logic [hwsi_pkg::HALF_W-1:0]        out_word_hi,
    output logic [hwsi_pkg::LEN_W-1:0]         out_word_len,
    output logic [hwsi_pkg::SLOT_W-1:0]        slot,
    output logic [hwsi_pkg::COUNT_W-1:0]       word_total
);

    typedef enum logic [9:0] {
        S_CLEAR     = 10'b0000000001,
        S_IDLE      = 10'b0000000010,
        S_HASH      = 10'b0000000100,
        S_PROBE_RD  = 10'b0000001000,
        S_PROBE_CHK = 10'b0000010000,
        S_RST_RD    = 10'b0000100000,
        S_RST_CLR   = 10'b0001000000,
        S_READ_ORD  = 10'b0010000000,
        S_READ_SLOT = 10'b0100000000,
        S_DONE      = 10'b1000000000
    } state_t;

    state_t                                 state_reg, state_next;
    logic [hwsi_pkg::SLOT_ADDR_W-1:0]       clr_idx_reg, clr_idx_next;
    logic [hwsi_pkg::WORD_W-1:0]            word_reg, word_next;
    logic [hwsi_pkg::LEN_W-1:0]             len_reg, len_next;
    logic [hwsi_pkg::POS_W-1:0]             pos_reg, pos_next;
    logic [hwsi_pkg::SLOT_ADDR_W-1:0]       idx_reg, idx_next;
    logic [hwsi_pkg::PROBE_W-1:0]           probe_reg, probe_next;
    logic [hwsi_pkg::COUNT_W-1:0]           count_reg, count_next;
    logic [hwsi_pkg::COUNT_W-1:0]           walk_reg, walk_next;
    logic                                   hash_start_reg, hash_start_next;
    hwsi_pkg::status_t                      res_status_reg, res_status_next;
    logic [hwsi_pkg::SLOT_ADDR_W-1:0]       res_slot_reg, res_slot_next;

    logic                                   out_valid_reg, out_valid_next;
    logic [hwsi_pkg::STATUS_W-1:0]          status_reg, status_next;
    logic [hwsi_pkg::HALF_W-1:0]            out_lo_reg, out_lo_next;
    logic [hwsi_pkg::HALF_W-1:0]            out_hi_reg, out_hi_next;
    logic [hwsi_pkg::LEN_W-1:0]             out_len_reg, out_len_next;
    logic [hwsi_pkg::SLOT_W-1:0]            slot_reg, slot_next;
    logic [hwsi_pkg::COUNT_W-1:0]           total_reg, total_next;

    hwsi_pkg::slot_entry_t                  slot_mem [hwsi_pkg::TABLE_SLOTS];
    hwsi_pkg::slot_entry_t                  slot_rdata_reg;
    hwsi_pkg::slot_entry_t                  slot_wdata;
    logic                                   slot_we;
    logic                                   slot_re;
    logic [hwsi_pkg::SLOT_ADDR_W-1:0]       slot_waddr;
    logic [hwsi_pkg::SLOT_ADDR_W-1:0]       slot_raddr;

    logic [hwsi_pkg::SLOT_ADDR_W-1:0]       order_mem [hwsi_pkg::MAX_WORDS];
    logic [hwsi_pkg::SLOT_ADDR_W-1:0]       order_rdata_reg;
    logic                                   order_we;
    logic                                   order_re;
    logic [hwsi_pkg::ORDER_ADDR_W-1:0]      order_raddr;

    hwsi_pkg::hash_stat_t                   hash_stat;
    logic [hwsi_pkg::SLOT_ADDR_W-1:0]       home_slot;

    logic                                   in_accept;
    logic                                   out_accept;
    logic [hwsi_pkg::LEN_W-1:0]             len_sat;
    logic [hwsi_pkg::WORD_W-1:0]            word_in;
    logic [hwsi_pkg::WORD_W-1:0]            word_masked;
    logic                                   word_match;
    logic [hwsi_pkg::SLOT_ADDR_W-1:0]       idx_wrap;

    hwsi_hash u_hash
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (hash_start_reg),
        .word      (word_reg),
        .len       (len_reg),
        .stat      (hash_stat),
        .home_slot (home_slot)
    );

    assign in_stall   = (state_reg != S_IDLE);
    assign in_accept  = in_valid && !in_stall;
    assign out_accept = out_valid_reg && !out_stall;

    assign len_sat = (word_len > hwsi_pkg::LEN_W'(hwsi_pkg::MAX_CHARS)) ?
                     hwsi_pkg::LEN_W'(hwsi_pkg::MAX_CHARS) : word_len;
    assign word_in = {word_hi, word_lo};

    always_comb
    begin
        for (int b = 0; b < hwsi_pkg::WORD_BYTES; b++)
        begin
            word_masked[b * hwsi_pkg::CHAR_W +: hwsi_pkg::CHAR_W] =
                (hwsi_pkg::LEN_W'(b) < len_sat) ?
                word_in[b * hwsi_pkg::CHAR_W +: hwsi_pkg::CHAR_W] : '0;
        end
    end

    assign word_match = (slot_rdata_reg.len == len_reg) &&
                        ({slot_rdata_reg.hi, slot_rdata_reg.lo} == word_reg);
    assign idx_wrap   = (idx_reg == hwsi_pkg::SLOT_ADDR_W'(hwsi_pkg::TABLE_SLOTS - 1)) ?
                        '0 : idx_reg + 1'b1;

    always_comb
    begin
        state_next      = state_reg;
        clr_idx_next    = clr_idx_reg;
        word_next       = word_reg;
        len_next        = len_reg;
        pos_next        = pos_reg;
        idx_next        = idx_reg;
        probe_next      = probe_reg;
        count_next      = count_reg;
        walk_next       = walk_reg;
        hash_start_next = 1'b0;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        out_valid_next  = out_valid_reg && !out_accept;
        status_next     = status_reg;
        out_lo_next     = out_lo_reg;
        out_hi_next     = out_hi_reg;
        out_len_next    = out_len_reg;
        slot_next       = slot_reg;
        total_next      = total_reg;
        slot_we         = 1'b0;
        slot_waddr      = idx_reg;
        slot_wdata      = '0;
        slot_re         = 1'b0;
        slot_raddr      = idx_reg;
        order_we        = 1'b0;
        order_re        = 1'b0;
        order_raddr     = pos_reg;

        case (state_reg)
            S_CLEAR:
            begin
                slot_we      = 1'b1;
                slot_waddr   = clr_idx_reg;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == hwsi_pkg::SLOT_ADDR_W'(hwsi_pkg::TABLE_SLOTS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_accept)
                begin
                    case (kind)
                        hwsi_pkg::KIND_INSERT:
                        begin
                            word_next       = word_masked;
                            len_next        = len_sat;
                            hash_start_next = 1'b1;
                            state_next      = S_HASH;
                        end
                        hwsi_pkg::KIND_RESET:
                        begin
                            walk_next     = '0;
                            res_slot_next = '0;
                            if (count_reg == '0)
                            begin
                                res_status_next = hwsi_pkg::STATUS_RESET;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                state_next = S_RST_RD;
                            end
                        end
                        hwsi_pkg::KIND_READ:
                        begin
                            pos_next      = position;
                            res_slot_next = '0;
                            if (hwsi_pkg::COUNT_W'(position) >= count_reg)
                            begin
                                res_status_next = hwsi_pkg::STATUS_OUT_RANGE;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                state_next = S_READ_ORD;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_HASH:
            begin
                if (hash_stat.done)
                begin
                    idx_next   = home_slot;
                    probe_next = '0;
                    state_next = S_PROBE_RD;
                end
            end
            S_PROBE_RD:
            begin
                slot_re    = 1'b1;
                slot_raddr = idx_reg;
                state_next = S_PROBE_CHK;
            end
            S_PROBE_CHK:
            begin
                state_next = S_DONE;
                if (!slot_rdata_reg.used)
                begin
                    if (count_reg >= hwsi_pkg::COUNT_W'(hwsi_pkg::MAX_WORDS))
                    begin
                        res_status_next = hwsi_pkg::STATUS_FULL;
                        res_slot_next   = '0;
                    end
                    else
                    begin
                        slot_we         = 1'b1;
                        slot_waddr      = idx_reg;
                        slot_wdata.used = 1'b1;
                        slot_wdata.len  = len_reg;
                        slot_wdata.hi   = word_reg[hwsi_pkg::WORD_W-1:hwsi_pkg::HALF_W];
                        slot_wdata.lo   = word_reg[hwsi_pkg::HALF_W-1:0];
                        order_we        = 1'b1;
                        count_next      = count_reg + 1'b1;
                        res_status_next = hwsi_pkg::STATUS_ADDED;
                        res_slot_next   = idx_reg;
                    end
                end
                else if (word_match)
                begin
                    res_status_next = hwsi_pkg::STATUS_PRESENT;
                    res_slot_next   = idx_reg;
                end
                else if (probe_reg == hwsi_pkg::PROBE_W'(hwsi_pkg::TABLE_SLOTS - 1))
                begin
                    res_status_next = hwsi_pkg::STATUS_FULL;
                    res_slot_next   = '0;
                end
                else
                begin
                    idx_next   = idx_wrap;
                    probe_next = probe_reg + 1'b1;
                    state_next = S_PROBE_RD;
                end
            end
            S_RST_RD:
            begin
                order_re    = 1'b1;
                order_raddr = walk_reg[hwsi_pkg::ORDER_ADDR_W-1:0];
                state_next  = S_RST_CLR;
            end
            S_RST_CLR:
            begin
                slot_we    = 1'b1;
                slot_waddr = order_rdata_reg;
                walk_next  = walk_reg + 1'b1;
                if (walk_reg + 1'b1 == count_reg)
                begin
                    count_next      = '0;
                    res_status_next = hwsi_pkg::STATUS_RESET;
                    state_next      = S_DONE;
                end
                else
                begin
                    state_next = S_RST_RD;
                end
            end
            S_READ_ORD:
            begin
                order_re    = 1'b1;
                order_raddr = pos_reg;
                state_next  = S_READ_SLOT;
            end
            S_READ_SLOT:
            begin
                slot_re         = 1'b1;
                slot_raddr      = order_rdata_reg;
                res_slot_next   = order_rdata_reg;
                res_status_next = hwsi_pkg::STATUS_READ_OK;
                state_next      = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    slot_next      = hwsi_pkg::SLOT_W'(res_slot_reg);
                    total_next     = count_reg;
                    if (res_status_reg == hwsi_pkg::STATUS_READ_OK)
                    begin
                        out_lo_next  = slot_rdata_reg.lo;
                        out_hi_next  = slot_rdata_reg.hi;
                        out_len_next = slot_rdata_reg.len;
                    end
                    else
                    begin
                        out_lo_next  = '0;
                        out_hi_next  = '0;
                        out_len_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_idx_reg    <= '0;
            count_reg      <= '0;
            hash_start_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_idx_reg    <= clr_idx_next;
            count_reg      <= count_next;
            hash_start_reg <= hash_start_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg       <= word_next;
        len_reg        <= len_next;
        pos_reg        <= pos_next;
        idx_reg        <= idx_next;
        probe_reg      <= probe_next;
        walk_reg       <= walk_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        status_reg     <= status_next;
        out_lo_reg     <= out_lo_next;
        out_hi_reg     <= out_hi_next;
        out_len_reg    <= out_len_next;
        slot_reg       <= slot_next;
        total_reg      <= total_next;
    end

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        if (slot_re)
        begin
            slot_rdata_reg <= slot_mem[slot_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (order_we)
        begin
            order_mem[count_reg[hwsi_pkg::ORDER_ADDR_W-1:0]] <= idx_reg;
        end
        if (order_re)
        begin
            order_rdata_reg <= order_mem[order_raddr];
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign out_word_lo  = out_lo_reg;
    assign out_word_hi  = out_hi_reg;
    assign out_word_len = out_len_reg;
    assign slot         = slot_reg;
    assign word_total   = total_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= hwsi_pkg::COUNT_W'(hwsi_pkg::MAX_WORDS))
        else $error("Stored word count exceeds the order list depth.");

    a_insert_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (order_we |-> (!slot_rdata_reg.used && state_reg == S_PROBE_CHK)))
        else $error("Insert wrote over a used slot.");

    a_hash_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (hash_stat.busy || hash_stat.done) |-> (state_reg == S_HASH))
        else $error("Hash unit active outside the hash phase.");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("Result transaction raised outside the completion state.");

    a_count_change: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
        ($past(state_reg == S_PROBE_CHK) || $past(state_reg == S_RST_CLR)))
        else $error("Stored word count changed outside insert or reset set.");

endmodule
